@@ hdl/tar_pkg.sv @@
`timescale 1ns / 1ps

package tar_pkg;

    localparam int COUNTER_BITS_DEF = 32;
    localparam int CPT_W            = 16;
    localparam int MIN_DELAY_W      = 4;
    localparam int MODE_W           = 2;
    localparam int DATA_W           = 32;
    localparam int APB_ADDR_W       = 4;
    localparam int APB_DATA_W       = 32;

    localparam logic [DATA_W-1:0]      REQ_FOREVER       = 32'hFFFF_FFFF;
    localparam logic [CPT_W-1:0]       CPT_RESET         = 16'd32;
    localparam logic                   TICKLESS_RESET    = 1'b1;
    localparam logic [MIN_DELAY_W-1:0] MIN_DELAY_RESET   = 4'd4;
    localparam logic                   BACKUP_RESET      = 1'b1;

    typedef enum logic [MODE_W-1:0] {
        MODE_QUERY   = 2'd0,
        MODE_COMPARE = 2'd1,
        MODE_TIMEOUT = 2'd2,
        MODE_RESTART = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_CPT       = 2'd0,
        REG_TICKLESS  = 2'd1,
        REG_MIN_DELAY = 2'd2,
        REG_BACKUP    = 2'd3
    } t_reg_idx;

endpackage

@@ hdl/tar_in_if.sv @@
`timescale 1ns / 1ps

interface tar_in_if;
    logic                           valid;
    logic                           ready;
    logic [tar_pkg::MODE_W-1:0]     mode;
    logic [tar_pkg::DATA_W-1:0]     now;
    logic signed [tar_pkg::DATA_W-1:0] requested_ticks;

    modport source (output valid, mode, now, requested_ticks, input ready);
    modport sink   (input valid, mode, now, requested_ticks, output ready);
endinterface

@@ hdl/tar_out_if.sv @@
`timescale 1ns / 1ps

interface tar_out_if;
    logic                        valid;
    logic                        ready;
    logic [tar_pkg::DATA_W-1:0]  tick_count;
    logic                        load_compare;
    logic [tar_pkg::DATA_W-1:0]  compare_delta;
    logic                        load_backup;
    logic [tar_pkg::DATA_W-1:0]  backup_delta;
    logic                        fire_now;

    modport source (output valid, tick_count, load_compare, compare_delta, load_backup,
                    backup_delta, fire_now, input ready);
    modport sink   (input valid, tick_count, load_compare, compare_delta, load_backup,
                    backup_delta, fire_now, output ready);
endinterface

@@ hdl/tick_accumulator_with_remainder.sv @@
`timescale 1ns / 1ps
// Queries in tickless mode and all compare events run a restoring divider from acceptance
// to result: one divider step per bit of the COUNTER_BITS+1 bit dividend, then a finish
// step. Set-timeout requests in tickless mode add a multiply step between the two. Other
// items go straight to the finish step. One item is in work at a time, and the next item
// is taken in the cycle after the result is registered; a held result delays the finish step.
// Synchronous active-low reset clears the state and loads the register defaults.
module tick_accumulator_with_remainder #(
    parameter int COUNTER_BITS = tar_pkg::COUNTER_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    tar_in_if.sink                           i_in,
    tar_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tar_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tar_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tar_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int CB     = COUNTER_BITS;
    localparam int DIV_W  = COUNTER_BITS + 1;
    localparam int CNT_W  = $clog2(DIV_W + 1);
    localparam int CPT_W  = tar_pkg::CPT_W;
    localparam int DW     = tar_pkg::DATA_W;
    localparam int MDW    = tar_pkg::MIN_DELAY_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_FIN
    } t_state;

    t_state                 r_state;
    logic [CPT_W-1:0]       r_cpt;
    logic                   r_tickless;
    logic [MDW-1:0]         r_min_delay;
    logic                   r_backup;

    logic [CB-1:0]          r_last_stamp;
    logic [CPT_W-1:0]       r_cycle_rem;
    logic [DW-1:0]          r_pending;

    tar_pkg::t_mode         r_mode;
    logic [CB-1:0]          r_now;
    logic [DW-1:0]          r_req;
    logic [DIV_W-1:0]       r_div_q;
    logic [CPT_W-1:0]       r_div_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic [DW-1:0]          r_prod;

    logic                   r_out_valid;
    logic [DW-1:0]          r_out_tick;
    logic                   r_out_ld_cmp;
    logic [DW-1:0]          r_out_cmp;
    logic                   r_out_ld_bak;
    logic [DW-1:0]          r_out_bak;
    logic                   r_out_fire;

    logic [CPT_W-1:0]       cpt_eff;
    logic                   cfg_wr;
    logic                   in_acc;
    logic                   out_free;
    tar_pkg::t_mode         in_mode;
    logic [CB-1:0]          elapsed;
    logic [DIV_W-1:0]       total;
    logic [CPT_W:0]         trial;
    logic                   ge;
    logic [CPT_W:0]         trial_sub;
    logic [CPT_W-1:0]       n_div_rem;
    logic [32:0]            q_ext;
    logic [DW-1:0]          q32;
    logic [DW-1:0]          tick_ceiling;
    logic [DW-1:0]          ticks;
    logic [DW+CPT_W-1:0]    product;
    logic [DW-1:0]          fold_pending;

    logic [DW-1:0]          n_tick;
    logic                   n_load;
    logic [DW-1:0]          n_delta;
    logic                   n_fire;

    assign cpt_eff  = (r_cpt == '0) ? CPT_W'(1) : r_cpt;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign in_mode  = tar_pkg::t_mode'(i_in.mode);
    assign i_in.ready = (r_state == S_IDLE);

    always_comb begin
        unique case (tar_pkg::t_reg_idx'(paddr[3:2]))
            tar_pkg::REG_CPT:       prdata = 32'(r_cpt);
            tar_pkg::REG_TICKLESS:  prdata = 32'(r_tickless);
            tar_pkg::REG_MIN_DELAY: prdata = 32'(r_min_delay);
            tar_pkg::REG_BACKUP:    prdata = 32'(r_backup);
        endcase
    end

    assign elapsed   = i_in.now[CB-1:0] - r_last_stamp;
    assign total     = DIV_W'(elapsed) + DIV_W'(r_cycle_rem);

    assign trial     = {r_div_rem, r_div_q[DIV_W-1]};
    assign ge        = trial >= {1'b0, cpt_eff};
    assign trial_sub = trial - {1'b0, cpt_eff};
    assign n_div_rem = ge ? trial_sub[CPT_W-1:0] : trial[CPT_W-1:0];

    assign q_ext        = 33'(r_div_q);
    assign q32          = q_ext[DW-1:0];
    assign tick_ceiling = (q32 >= 32'd2) ? (q32 - 32'd1) : 32'd1;
    assign fold_pending = r_pending + q32;

    always_comb begin
        if (r_req == tar_pkg::REQ_FOREVER) begin
            ticks = tick_ceiling;
        end else if (r_req[DW-1] || r_req == '0) begin
            ticks = 32'd1;
        end else if (r_req > tick_ceiling) begin
            ticks = tick_ceiling;
        end else begin
            ticks = r_req;
        end
    end

    assign product = ticks * cpt_eff;

    always_comb begin
        n_tick  = '0;
        n_load  = 1'b0;
        n_delta = '0;
        n_fire  = 1'b0;
        unique case (r_mode)
            tar_pkg::MODE_QUERY: begin
                if (r_tickless) begin
                    n_tick = fold_pending;
                end
            end
            tar_pkg::MODE_COMPARE: begin
                n_tick = fold_pending;
                if (!r_tickless) begin
                    n_load  = 1'b1;
                    n_delta = (cpt_eff < CPT_W'(r_min_delay)) ? 32'(r_min_delay)
                                                              : 32'(cpt_eff);
                end
            end
            tar_pkg::MODE_TIMEOUT: begin
                if (r_tickless) begin
                    if (r_prod <= 32'(r_min_delay)) begin
                        n_fire = 1'b1;
                    end else begin
                        n_load  = 1'b1;
                        n_delta = r_prod;
                    end
                end
            end
            tar_pkg::MODE_RESTART: begin
                if (!r_tickless) begin
                    n_load  = 1'b1;
                    n_delta = 32'(cpt_eff);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cpt        <= tar_pkg::CPT_RESET;
            r_tickless   <= tar_pkg::TICKLESS_RESET;
            r_min_delay  <= tar_pkg::MIN_DELAY_RESET;
            r_backup     <= tar_pkg::BACKUP_RESET;
            r_last_stamp <= '0;
            r_cycle_rem  <= '0;
            r_pending    <= '0;
            r_out_valid  <= 1'b0;
            r_cnt        <= '0;
        end else begin
            if (cfg_wr) begin
                unique case (tar_pkg::t_reg_idx'(paddr[3:2]))
                    tar_pkg::REG_CPT:       r_cpt       <= pwdata[CPT_W-1:0];
                    tar_pkg::REG_TICKLESS:  r_tickless  <= pwdata[0];
                    tar_pkg::REG_MIN_DELAY: r_min_delay <= pwdata[MDW-1:0];
                    tar_pkg::REG_BACKUP:    r_backup    <= pwdata[0];
                endcase
            end

            if (r_out_valid && o_out.ready && r_state != S_FIN) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_mode    <= in_mode;
                        r_now     <= i_in.now[CB-1:0];
                        r_req     <= i_in.requested_ticks;
                        r_div_rem <= '0;
                        r_cnt     <= CNT_W'(DIV_W);
                        if ((in_mode == tar_pkg::MODE_QUERY && r_tickless) ||
                            in_mode == tar_pkg::MODE_COMPARE) begin
                            r_div_q <= total;
                            r_state <= S_DIV;
                        end else if (in_mode == tar_pkg::MODE_TIMEOUT && r_tickless) begin
                            r_div_q <= {1'b0, {CB{1'b1}}};
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_DIV: begin
                    r_div_rem <= n_div_rem;
                    r_div_q   <= {r_div_q[DIV_W-2:0], ge};
                    r_cnt     <= r_cnt - CNT_W'(1);
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= (r_mode == tar_pkg::MODE_TIMEOUT) ? S_MUL : S_FIN;
                    end
                end
                S_MUL: begin
                    r_prod  <= product[DW-1:0];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_tick   <= n_tick;
                        r_out_ld_cmp <= n_load;
                        r_out_cmp    <= n_delta;
                        r_out_ld_bak <= n_load && r_backup;
                        r_out_bak    <= (n_load && r_backup) ? (n_delta + 32'd1) : '0;
                        r_out_fire   <= n_fire;
                        unique case (r_mode)
                            tar_pkg::MODE_QUERY: begin
                                if (r_tickless) begin
                                    r_pending    <= fold_pending;
                                    r_cycle_rem  <= r_div_rem;
                                    r_last_stamp <= r_now;
                                end
                            end
                            tar_pkg::MODE_COMPARE: begin
                                r_pending    <= '0;
                                r_cycle_rem  <= r_div_rem;
                                r_last_stamp <= r_now;
                            end
                            tar_pkg::MODE_TIMEOUT: begin
                            end
                            tar_pkg::MODE_RESTART: begin
                                r_cycle_rem  <= '0;
                                r_last_stamp <= r_now;
                            end
                        endcase
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.tick_count    = r_out_tick;
    assign o_out.load_compare  = r_out_ld_cmp;
    assign o_out.compare_delta = r_out_cmp;
    assign o_out.load_backup   = r_out_ld_bak;
    assign o_out.backup_delta  = r_out_bak;
    assign o_out.fire_now      = r_out_fire;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in.ready)
        else $error("input taken while an item is in work");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt != '0)
        else $error("divider running with an empty step count");

    a_div_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_div_rem < cpt_eff)
        else $error("partial remainder not below the divisor");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN))
        else $error("result raised outside the finish step");

endmodule
